// ----- design/ialu_pkg.sv -----
// Package for the 22-operation integer ALU.
// Holds the opcodes, status codes and the control word passed along the cell chain.
// No dependencies.
package ialu_pkg;

    typedef enum logic [4:0] {
        OP_ADD    = 5'd1,
        OP_SUB    = 5'd2,
        OP_MUL    = 5'd3,
        OP_DIV    = 5'd4,
        OP_MOD    = 5'd5,
        OP_GT     = 5'd6,
        OP_LT     = 5'd7,
        OP_GE     = 5'd8,
        OP_LE     = 5'd9,
        OP_EQ     = 5'd10,
        OP_NE     = 5'd11,
        OP_LAND   = 5'd12,
        OP_LOR    = 5'd13,
        OP_LNOT   = 5'd14,
        OP_INC    = 5'd15,
        OP_DEC    = 5'd16,
        OP_AND    = 5'd17,
        OP_OR     = 5'd18,
        OP_XOR    = 5'd19,
        OP_SHL    = 5'd20,
        OP_SAR    = 5'd21,
        OP_NOT    = 5'd22
    } op_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_OP    = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_DIV_OVF   = 3'd3;
    localparam logic [2:0] ST_BAD_SHIFT = 3'd4;

    localparam int OUT_LIMIT = 32;

    typedef struct packed {
        logic       vld;
        logic       is_div;
        logic       is_mod;
        logic       neg_q;
        logic       neg_r;
        logic [2:0] status;
    } ctrl_t;

endpackage

// ----- design/ialu_front.sv -----
// Front stage: decodes the opcode, works out every operation but division and
// modulo, and prepares operand magnitudes for the division chain. Uses ialu_pkg.
module ialu_front
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld,
    input  logic [4:0]            action,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output ctrl_t                 ctrl,
    output logic [DATA_WIDTH-1:0] rslt,
    output logic [DATA_WIDTH-1:0] dvd,
    output logic [DATA_WIDTH-1:0] dsr
);
    localparam int SHW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] ONE     = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [DATA_WIDTH-1:0] ZERO    = '0;
    localparam logic [DATA_WIDTH-1:0] W_VAL   = DATA_WIDTH'(DATA_WIDTH);

    ctrl_t                 ctrl_reg, ctrl_next;
    logic [DATA_WIDTH-1:0] rslt_reg, rslt_next;
    logic [DATA_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DATA_WIDTH-1:0] dsr_reg, dsr_next;

    logic signed [DATA_WIDTH-1:0] sa, sb;
    logic [SHW-1:0]               sh;
    logic                         sh_ok, b_zero, ovf;

    always_comb
    begin
        sa     = $signed(operand_a);
        sb     = $signed(operand_b);
        sh     = operand_b[SHW-1:0];
        sh_ok  = operand_b < W_VAL;
        b_zero = operand_b == ZERO;
        ovf    = (operand_a == MIN_VAL) && (operand_b == '1);

        ctrl_next        = '0;
        ctrl_next.vld    = vld;
        ctrl_next.status = ST_OK;
        ctrl_next.neg_q  = operand_a[DATA_WIDTH-1] ^ operand_b[DATA_WIDTH-1];
        ctrl_next.neg_r  = operand_a[DATA_WIDTH-1];
        dvd_next = operand_a[DATA_WIDTH-1] ? (ZERO - operand_a) : operand_a;
        dsr_next = operand_b[DATA_WIDTH-1] ? (ZERO - operand_b) : operand_b;
        rslt_next = ZERO;

        case (action)
            OP_ADD:  rslt_next = operand_a + operand_b;
            OP_SUB:  rslt_next = operand_a - operand_b;
            OP_MUL:  rslt_next = operand_a * operand_b;
            OP_DIV, OP_MOD:
            begin
                if (b_zero)
                    ctrl_next.status = ST_DIV_ZERO;
                else if (ovf)
                    ctrl_next.status = ST_DIV_OVF;
                ctrl_next.is_div = action == OP_DIV;
                ctrl_next.is_mod = action == OP_MOD;
            end
            OP_GT:   rslt_next = (sa > sb) ? ONE : ZERO;
            OP_LT:   rslt_next = (sa < sb) ? ONE : ZERO;
            OP_GE:   rslt_next = (sa >= sb) ? ONE : ZERO;
            OP_LE:   rslt_next = (sa <= sb) ? ONE : ZERO;
            OP_EQ:   rslt_next = (operand_a == operand_b) ? ONE : ZERO;
            OP_NE:   rslt_next = (operand_a != operand_b) ? ONE : ZERO;
            OP_LAND: rslt_next = ((operand_a != ZERO) && !b_zero) ? ONE : ZERO;
            OP_LOR:  rslt_next = ((operand_a != ZERO) || !b_zero) ? ONE : ZERO;
            OP_LNOT: rslt_next = (operand_a == ZERO) ? ONE : ZERO;
            OP_INC:  rslt_next = operand_a + ONE;
            OP_DEC:  rslt_next = operand_a - ONE;
            OP_AND:  rslt_next = operand_a & operand_b;
            OP_OR:   rslt_next = operand_a | operand_b;
            OP_XOR:  rslt_next = operand_a ^ operand_b;
            OP_SHL:
            begin
                if (sh_ok)
                    rslt_next = operand_a << sh;
                else
                    ctrl_next.status = ST_BAD_SHIFT;
            end
            OP_SAR:
            begin
                if (sh_ok)
                    rslt_next = $unsigned(sa >>> sh);
                else
                    ctrl_next.status = ST_BAD_SHIFT;
            end
            OP_NOT:  rslt_next = ~operand_a;
            default: ctrl_next.status = ST_BAD_OP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rslt_reg <= rslt_next;
            dvd_reg  <= dvd_next;
            dsr_reg  <= dsr_next;
        end
    end

    assign ctrl = ctrl_reg;
    assign rslt = rslt_reg;
    assign dvd  = dvd_reg;
    assign dsr  = dsr_reg;

endmodule

// ----- design/ialu_div_cell.sv -----
// One restoring-division cell: develops one quotient bit per beat.
// Carries the control word and the front-stage result alongside. Uses ialu_pkg.
module ialu_div_cell
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  ctrl_t                 ctrl_i,
    input  logic [DATA_WIDTH-1:0] rslt_i,
    input  logic [DATA_WIDTH-1:0] rem_i,
    input  logic [DATA_WIDTH-1:0] quo_i,
    input  logic [DATA_WIDTH-1:0] dsr_i,
    output ctrl_t                 ctrl_o,
    output logic [DATA_WIDTH-1:0] rslt_o,
    output logic [DATA_WIDTH-1:0] rem_o,
    output logic [DATA_WIDTH-1:0] quo_o,
    output logic [DATA_WIDTH-1:0] dsr_o
);
    ctrl_t                 ctrl_reg;
    logic [DATA_WIDTH-1:0] rslt_reg;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] dsr_reg;
    logic [DATA_WIDTH-1:0] trial;
    logic                  qbit;

    always_comb
    begin
        trial    = {rem_i[DATA_WIDTH-2:0], quo_i[DATA_WIDTH-1]};
        qbit     = trial >= dsr_i;
        rem_next = qbit ? (trial - dsr_i) : trial;
        quo_next = {quo_i[DATA_WIDTH-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rslt_reg <= rslt_i;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= dsr_i;
        end
    end

    assign ctrl_o = ctrl_reg;
    assign rslt_o = rslt_reg;
    assign rem_o  = rem_reg;
    assign quo_o  = quo_reg;
    assign dsr_o  = dsr_reg;

endmodule

// ----- design/ialu_back.sv -----
// Output stage: applies signs to quotient and remainder, picks the result
// and holds the result beat until taken. Uses ialu_pkg.
module ialu_back
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  ctrl_t                 ctrl_i,
    input  logic [DATA_WIDTH-1:0] rslt_i,
    input  logic [DATA_WIDTH-1:0] rem_i,
    input  logic [DATA_WIDTH-1:0] quo_i,
    output logic                  vld,
    output logic [DATA_WIDTH-1:0] result,
    output logic [2:0]            status
);
    localparam int OUT_BITS = (DATA_WIDTH < OUT_LIMIT) ? DATA_WIDTH : OUT_LIMIT;
    localparam logic [DATA_WIDTH-1:0] RES_MASK = {DATA_WIDTH{1'b1}} >> (DATA_WIDTH - OUT_BITS);

    logic                  vld_reg;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic [2:0]            st_reg;

    always_comb
    begin
        if (ctrl_i.status != ST_OK)
            res_next = '0;
        else if (ctrl_i.is_div)
            res_next = ctrl_i.neg_q ? ('0 - quo_i) : quo_i;
        else if (ctrl_i.is_mod)
            res_next = ctrl_i.neg_r ? ('0 - rem_i) : rem_i;
        else
            res_next = rslt_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= ctrl_i.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next & RES_MASK;
            st_reg  <= ctrl_i.status;
        end
    end

    assign vld    = vld_reg;
    assign result = res_reg;
    assign status = st_reg;

endmodule

// ----- design/integer_alu_22_ops.sv -----
// Channel | valid      | stall      | payload
// item    | item_valid | item_stall | action, operand_a, operand_b
// result  | res_valid  | res_stall  | result, status
// One beat accepted per cycle while item_stall is low; each beat passes the front stage,
// the chain of division cells, one quotient bit per cell, and the output stage.
// The whole chain advances unless a held result beat is stalled.
// Reset clears the control words and the valid flag; no state survives between beats.
module integer_alu_22_ops
    import ialu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [4:0]            action,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [DATA_WIDTH-1:0] result,
    output logic [2:0]            status
);
    logic en;

    ctrl_t                 ctrl [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] rslt [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] rem  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] quo  [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] dsr  [DATA_WIDTH+1];

    assign en         = !(res_valid && res_stall);
    assign item_stall = !en;
    assign rem[0]     = '0;

    ialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vld       (item_valid),
        .action    (action),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .ctrl      (ctrl[0]),
        .rslt      (rslt[0]),
        .dvd       (quo[0]),
        .dsr       (dsr[0])
    );

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        ialu_div_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctrl_i (ctrl[i]),
            .rslt_i (rslt[i]),
            .rem_i  (rem[i]),
            .quo_i  (quo[i]),
            .dsr_i  (dsr[i]),
            .ctrl_o (ctrl[i+1]),
            .rslt_o (rslt[i+1]),
            .rem_o  (rem[i+1]),
            .quo_o  (quo[i+1]),
            .dsr_o  (dsr[i+1])
        );
    end

    ialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctrl_i (ctrl[DATA_WIDTH]),
        .rslt_i (rslt[DATA_WIDTH]),
        .rem_i  (rem[DATA_WIDTH]),
        .quo_i  (quo[DATA_WIDTH]),
        .vld    (res_valid),
        .result (result),
        .status (status)
    );

endmodule
